// ----- design/nfp_pkg.sv -----
// Shared types and constants for the flash pulse program/erase sequencer.
// Depends on nothing; used by every design file.
package nfp_pkg;

  localparam int unsigned AddrBits = 24;

  typedef logic [AddrBits-1:0] addr_t;

  // operation codes
  localparam logic [1:0] OpProgram  = 2'd0;
  localparam logic [1:0] OpErase    = 2'd1;
  localparam logic [1:0] OpResponse = 2'd2;

  // request kinds
  localparam logic [2:0] KindCmdWriteWord = 3'd0;
  localparam logic [2:0] KindCmdReadWord  = 3'd1;
  localparam logic [2:0] KindWriteByte    = 3'd2;
  localparam logic [2:0] KindCmdReadByte  = 3'd3;
  localparam logic [2:0] KindWait10ms     = 3'd4;
  localparam logic [2:0] KindByteMode     = 3'd5;
  localparam logic [2:0] KindFinished     = 3'd6;

  // status codes
  localparam logic [1:0] StatBusy = 2'd0;
  localparam logic [1:0] StatOk   = 2'd1;
  localparam logic [1:0] StatFail = 2'd2;

  // configuration register indexes
  localparam logic CfgProgramLimit = 1'b0;
  localparam logic CfgEraseLimit   = 1'b1;

  localparam logic [7:0]  ProgramLimitReset = 8'd25;
  localparam logic [15:0] EraseLimitReset   = 16'd1000;

  // flash command words
  localparam logic [15:0] CmdProgram = 16'h4040;
  localparam logic [15:0] CmdVerify  = 16'hc0c0;
  localparam logic [15:0] CmdReset   = 16'hffff;
  localparam logic [15:0] CmdErase   = 16'h0020;
  localparam logic [15:0] CmdEraseVf = 16'h00a0;
  localparam logic [15:0] MaskHiOnly = 16'hff00;
  localparam logic [15:0] MaskLoOnly = 16'h00ff;
  localparam logic [7:0]  ErasedByte = 8'hff;

  // sequencer phases
  localparam int unsigned PhaseBits = 4;
  localparam logic [PhaseBits-1:0] PhIdle      = 4'd0;
  localparam logic [PhaseBits-1:0] PhPRead     = 4'd1;
  localparam logic [PhaseBits-1:0] PhPWrite    = 4'd2;
  localparam logic [PhaseBits-1:0] PhPVerify   = 4'd3;
  localparam logic [PhaseBits-1:0] PhFailReset = 4'd4;
  localparam logic [PhaseBits-1:0] PhEReset0   = 4'd5;
  localparam logic [PhaseBits-1:0] PhEByteMode = 4'd6;
  localparam logic [PhaseBits-1:0] PhEErase1   = 4'd7;
  localparam logic [PhaseBits-1:0] PhEErase2   = 4'd8;
  localparam logic [PhaseBits-1:0] PhEWait     = 4'd9;
  localparam logic [PhaseBits-1:0] PhEVerify   = 4'd10;
  localparam logic [PhaseBits-1:0] PhENull     = 4'd11;
  localparam logic [PhaseBits-1:0] PhEResetEnd = 4'd12;

  typedef struct packed {
    logic [1:0]  operation;
    addr_t       address;
    addr_t       end_address;
    logic [15:0] value;
    logic        response_ok;
    logic [15:0] response_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  request_kind;
    addr_t       request_address;
    logic [15:0] request_command;
    logic [15:0] request_data;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [PhaseBits-1:0] phase;
    addr_t                cur_addr;
    addr_t                first_addr;
    addr_t                stop_addr;
    logic [15:0]          target_word;
    logic [15:0]          byte_mask;
    logic [7:0]           prog_pulses;
    logic [15:0]          erase_pulses;
    logic                 erase_active;
  } seq_state_t;

  localparam seq_state_t StateReset = '{
    phase:        PhIdle,
    cur_addr:     '0,
    first_addr:   '0,
    stop_addr:    '0,
    target_word:  16'h0000,
    byte_mask:    16'hffff,
    prog_pulses:  8'd0,
    erase_pulses: 16'd0,
    erase_active: 1'b0
  };

endpackage

// ----- design/nor_flash_pulse_program_erase.sv -----
// Top level of the quick-pulse program/erase sequencer for a NOR flash.
// Depends on nfp_pkg and nfp_step.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o / in_data_i) carries start
//    transfers (program a word, erase a range) and bus responses.
//  - Output channel (out_valid_o / out_ready_i / out_data_o) carries the
//    next bus request, or a finished marker with the job status.
//  - Each input transfer yields at most one output transfer. Starts always
//    yield one; responses while idle yield none.
//  - Latency: the request for an accepted transfer is in the output register
//    on the following cycle. Throughput: one transfer per cycle while the
//    output register is not stalled, as nfp_step is combinational.
//  - The output register decouples the sides: a new input transfer is taken
//    while a request waits, as long as the receiver takes it in the same
//    cycle or the register is empty. A stalled receiver holds in_ready_o low.
//  - Reset: sequencer idle, pulse limits back to 25 (program) and 1000
//    (erase), output register empty.
//  - Config writes (cfg_we_i) are registered; issue them only while idle.
module nor_flash_pulse_program_erase (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nfp_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nfp_pkg::out_item_t  out_data_o
);

  logic [7:0]          prog_limit_q;
  logic [15:0]         erase_limit_q;
  nfp_pkg::seq_state_t state_q, state_d;
  nfp_pkg::out_item_t  res_d, out_q;
  logic                emit;
  logic                out_valid_q;
  logic                in_xfer;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_limit_q  <= nfp_pkg::ProgramLimitReset;
      erase_limit_q <= nfp_pkg::EraseLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nfp_pkg::CfgProgramLimit: prog_limit_q  <= cfg_data_i[7:0];
        nfp_pkg::CfgEraseLimit:   erase_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // accept when the output register is empty or being drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  nfp_step u_step (
    .st_i          (state_q),
    .item_i        (in_data_i),
    .prog_limit_i  (prog_limit_q),
    .erase_limit_i (erase_limit_q),
    .st_o          (state_d),
    .res_o         (res_d),
    .emit_o        (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfp_pkg::StateReset;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/nfp_step.sv -----
// Next-state and request logic for one transfer of the sequencer.
// Depends on nfp_pkg.
module nfp_step (
  input  nfp_pkg::seq_state_t st_i,
  input  nfp_pkg::in_item_t   item_i,
  input  logic [7:0]          prog_limit_i,
  input  logic [15:0]         erase_limit_i,
  output nfp_pkg::seq_state_t st_o,
  output nfp_pkg::out_item_t  res_o,
  output logic                emit_o
);

  typedef struct packed {
    nfp_pkg::seq_state_t st;
    nfp_pkg::out_item_t  res;
  } step_t;

  function automatic nfp_pkg::out_item_t mk(logic [2:0] kind, nfp_pkg::addr_t a,
                                            logic [15:0] cmd, logic [15:0] dat,
                                            logic [1:0] stat);
    nfp_pkg::out_item_t r;
    r.request_kind    = kind;
    r.request_address = a;
    r.request_command = cmd;
    r.request_data    = dat;
    r.status          = stat;
    return r;
  endfunction

  function automatic step_t reset_req(nfp_pkg::seq_state_t s,
                                      logic [nfp_pkg::PhaseBits-1:0] nxt);
    step_t r;
    r.st       = s;
    r.st.phase = nxt;
    r.res      = mk(nfp_pkg::KindCmdWriteWord, '0, nfp_pkg::CmdReset,
                    nfp_pkg::CmdReset, nfp_pkg::StatBusy);
    return r;
  endfunction

  function automatic step_t finish(nfp_pkg::seq_state_t s, logic ok);
    step_t r;
    r.st       = s;
    r.st.phase = nfp_pkg::PhIdle;
    r.res      = mk(nfp_pkg::KindFinished, '0, 16'h0000, 16'h0000,
                    ok ? nfp_pkg::StatOk : nfp_pkg::StatFail);
    return r;
  endfunction

  // next word of the zero fill, or byte mode once the range is done
  function automatic step_t zero_loop(nfp_pkg::seq_state_t s, nfp_pkg::addr_t a);
    step_t r;
    r.st          = s;
    r.st.cur_addr = a;
    if (a < s.stop_addr) begin
      r.st.target_word = 16'h0000;
      r.st.byte_mask   = 16'hffff;
      r.st.prog_pulses = 8'd0;
      r.st.phase       = nfp_pkg::PhPRead;
      r.res = mk(nfp_pkg::KindCmdReadWord, a, 16'h0000, 16'h0000, nfp_pkg::StatBusy);
    end else begin
      r.st.cur_addr = s.first_addr;
      r.st.phase    = nfp_pkg::PhEByteMode;
      r.res = mk(nfp_pkg::KindByteMode, '0, 16'h0000, 16'h0000, nfp_pkg::StatBusy);
    end
    return r;
  endfunction

  function automatic step_t null_write(nfp_pkg::seq_state_t s);
    step_t r;
    r.st       = s;
    r.st.phase = nfp_pkg::PhENull;
    r.res = mk(nfp_pkg::KindWriteByte, s.first_addr, 16'h0000, 16'h0000,
               nfp_pkg::StatBusy);
    return r;
  endfunction

  function automatic step_t erase_outer(nfp_pkg::seq_state_t s, logic [15:0] base,
                                        nfp_pkg::addr_t a, logic [15:0] lim);
    step_t       r;
    logic [15:0] cnt;
    cnt               = base + 16'd1;
    r.st              = s;
    r.st.cur_addr     = a;
    r.st.erase_pulses = cnt;
    if (cnt < lim && a < s.stop_addr) begin
      r.st.phase = nfp_pkg::PhEErase1;
      r.res = mk(nfp_pkg::KindWriteByte, a, 16'h0000, nfp_pkg::CmdErase,
                 nfp_pkg::StatBusy);
    end else begin
      r = null_write(r.st);
    end
    return r;
  endfunction

  function automatic step_t erase_inner(nfp_pkg::seq_state_t s, nfp_pkg::addr_t a,
                                        logic [15:0] lim);
    step_t r;
    r.st          = s;
    r.st.cur_addr = a;
    if (a < s.stop_addr) begin
      r.st.phase = nfp_pkg::PhEVerify;
      r.res = mk(nfp_pkg::KindCmdReadByte, a, nfp_pkg::CmdEraseVf, 16'h0000,
                 nfp_pkg::StatBusy);
    end else begin
      r = erase_outer(s, s.erase_pulses, a, lim);
    end
    return r;
  endfunction

  // read-back compare: done, one more masked pulse, or a fail reset at the pulse limit
  function automatic step_t prog_check(nfp_pkg::seq_state_t s, logic [15:0] seen,
                                       logic [7:0] lim);
    step_t       r;
    logic [7:0]  cnt;
    logic [15:0] msk;
    cnt  = s.prog_pulses + 8'd1;
    msk  = s.byte_mask;
    r.st = s;
    if (seen == s.target_word) begin
      if (s.erase_active) begin
        r = zero_loop(s, s.cur_addr + nfp_pkg::AddrBits'(2));
      end else begin
        r = finish(s, 1'b1);
      end
    end else begin
      r.st.prog_pulses = cnt;
      if (cnt < lim) begin
        if (seen[7:0] == s.target_word[7:0]) begin
          msk = msk & nfp_pkg::MaskHiOnly;
        end
        if (seen[15:8] == s.target_word[15:8]) begin
          msk = msk & nfp_pkg::MaskLoOnly;
        end
        r.st.byte_mask = msk;
        r.st.phase     = nfp_pkg::PhPWrite;
        r.res = mk(nfp_pkg::KindCmdWriteWord, s.cur_addr, nfp_pkg::CmdProgram & msk,
                   s.target_word, nfp_pkg::StatBusy);
      end else begin
        r = reset_req(r.st, nfp_pkg::PhFailReset);
      end
    end
    return r;
  endfunction

  step_t          nx;
  nfp_pkg::addr_t addr_inc;

  assign addr_inc = st_i.cur_addr + nfp_pkg::AddrBits'(1);

  always_comb begin
    nx.st  = st_i;
    nx.res = '0;
    emit_o = 1'b0;
    case (item_i.operation)
      nfp_pkg::OpProgram: begin
        nx.st.erase_active = 1'b0;
        nx.st.cur_addr     = item_i.address;
        nx.st.target_word  = item_i.value;
        nx.st.byte_mask    = 16'hffff;
        nx.st.prog_pulses  = 8'd0;
        nx.st.phase        = nfp_pkg::PhPRead;
        nx.res = mk(nfp_pkg::KindCmdReadWord, item_i.address, 16'h0000, 16'h0000,
                    nfp_pkg::StatBusy);
        emit_o = 1'b1;
      end
      nfp_pkg::OpErase: begin
        nx.st.erase_active = 1'b1;
        nx.st.first_addr   = item_i.address;
        nx.st.stop_addr    = item_i.end_address;
        nx.st.cur_addr     = item_i.address;
        nx.st.erase_pulses = 16'd0;
        nx = reset_req(nx.st, nfp_pkg::PhEReset0);
        emit_o = 1'b1;
      end
      nfp_pkg::OpResponse: begin
        emit_o = 1'b1;
        case (st_i.phase)
          nfp_pkg::PhPRead: begin
            if (!item_i.response_ok) nx = finish(st_i, 1'b0);
            else nx = prog_check(st_i, item_i.response_data, prog_limit_i);
          end
          nfp_pkg::PhPWrite: begin
            if (!item_i.response_ok) begin
              nx = reset_req(st_i, nfp_pkg::PhFailReset);
            end else begin
              nx.st.phase = nfp_pkg::PhPVerify;
              nx.res = mk(nfp_pkg::KindCmdReadWord, st_i.cur_addr,
                          nfp_pkg::CmdVerify & st_i.byte_mask, 16'h0000,
                          nfp_pkg::StatBusy);
            end
          end
          nfp_pkg::PhPVerify: begin
            if (!item_i.response_ok) nx = reset_req(st_i, nfp_pkg::PhFailReset);
            else nx = prog_check(st_i, item_i.response_data, prog_limit_i);
          end
          nfp_pkg::PhFailReset: begin
            nx = finish(st_i, 1'b0);
          end
          nfp_pkg::PhEReset0: begin
            if (!item_i.response_ok) nx = finish(st_i, 1'b0);
            else nx = zero_loop(st_i, st_i.cur_addr);
          end
          nfp_pkg::PhEByteMode: begin
            if (!item_i.response_ok) nx = reset_req(st_i, nfp_pkg::PhFailReset);
            else nx = erase_outer(st_i, 16'd0, st_i.cur_addr, erase_limit_i);
          end
          nfp_pkg::PhEErase1: begin
            if (!item_i.response_ok) begin
              nx = null_write(st_i);
            end else begin
              nx.st.phase = nfp_pkg::PhEErase2;
              nx.res = mk(nfp_pkg::KindWriteByte, st_i.cur_addr, 16'h0000,
                          nfp_pkg::CmdErase, nfp_pkg::StatBusy);
            end
          end
          nfp_pkg::PhEErase2: begin
            if (!item_i.response_ok) begin
              nx = null_write(st_i);
            end else begin
              nx.st.phase = nfp_pkg::PhEWait;
              nx.res = mk(nfp_pkg::KindWait10ms, '0, 16'h0000, 16'h0000,
                          nfp_pkg::StatBusy);
            end
          end
          nfp_pkg::PhEWait: begin
            nx = erase_inner(st_i, st_i.cur_addr, erase_limit_i);
          end
          nfp_pkg::PhEVerify: begin
            if (!item_i.response_ok ||
                item_i.response_data[7:0] != nfp_pkg::ErasedByte) begin
              nx = erase_outer(st_i, st_i.erase_pulses, st_i.cur_addr, erase_limit_i);
            end else begin
              nx = erase_inner(st_i, addr_inc, erase_limit_i);
            end
          end
          nfp_pkg::PhENull: begin
            nx = reset_req(st_i, nfp_pkg::PhEResetEnd);
          end
          nfp_pkg::PhEResetEnd: begin
            nx = finish(st_i, st_i.cur_addr == st_i.stop_addr);
          end
          default: begin
            // idle or an unused code: drop the response
            nx.st.phase = nfp_pkg::PhIdle;
            emit_o      = 1'b0;
          end
        endcase
      end
      default: begin
        // unused operation code: no effect
      end
    endcase
  end

  assign st_o  = nx.st;
  assign res_o = nx.res;

endmodule

// ----- design/nfp_checker.sv -----
// Port-level assertions for the sequencer, bound to the top level.
// Depends on nfp_pkg and nor_flash_pulse_program_erase.
module nfp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input nfp_pkg::out_item_t out_data_o
);

  // a waiting request is not dropped or altered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output request changed while stalled");

  // empty output register never blocks the input side
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // status is set exactly on the finished marker
  a_status_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.request_kind == nfp_pkg::KindFinished) ==
                     (out_data_o.status != nfp_pkg::StatBusy)))
    else $error("status and request kind disagree");

  // only defined kinds and status codes leave the block
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.request_kind <= nfp_pkg::KindFinished) &&
                    (out_data_o.status <= nfp_pkg::StatFail))
    else $error("undefined request kind or status");

endmodule

bind nor_flash_pulse_program_erase nfp_checker u_nfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
